>>> rtl/ftac_pkg.sv
// Shared types and constants of the floating-point all-close checker.
// No dependencies; used by the front, the queue, the back and the top level.
`default_nettype none

package ftac_pkg;

    localparam int FTAC_QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSOLUTE_TOL   = 2'd2;

    localparam logic [30:0] F32_INF_MAG = 31'h7F800000;
    localparam logic [30:0] F32_NAN_MAG = 31'h7FC00000;

    // Classified element pair; x holds the larger magnitude.
    typedef struct packed {
        logic [30:0] mag_x;
        logic [30:0] mag_y;
        logic [30:0] m_mag;
        logic        eff_sub;
        logic        diff_nan;
        logic        diff_inf;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_NORM,
        ST_ROUND,
        ST_CHECK,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/float_tensor_allclose_checker.sv
// Usage:
//   Input channel (i_valid / o_stall) carries one element pair per transfer:
//   i_value_a, i_value_b and i_last_element. A pair is taken at a clock edge
//   with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) carries one verdict, o_all_close, per
//   pair marked last; earlier pairs only update the sticky mismatch flag.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 element format, 1 rtol bits, 2 atol bits); the user must write only
//   while the block is idle, as the block itself does not enforce it.
//   Each pair passes through the back end in order: it leaves the queue, then
//   align/add with multiply, normalize, round and compare. The back end
//   sequencer takes a new pair only when done with the last; a pair marked
//   last then shows its verdict on o_valid and holds it until taken.
//   A two-entry queue lets the front keep taking pairs while the back end
//   works or a verdict waits; o_stall rises only when that queue is full.
//   Synchronous active-low reset empties the queue, clears the flag and the
//   registers; no clearing pass is needed.
`default_nettype none

module float_tensor_allclose_checker #(
    parameter int QUEUE_DEPTH = ftac_pkg::FTAC_QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [31:0]                   i_value_a,
    input  wire logic [31:0]                   i_value_b,
    input  wire logic                          i_last_element,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_all_close,
    input  wire logic                          i_cfg_we,
    input  wire logic [ftac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ftac_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ftac_pkg::*;

    logic        r_fp16;
    logic [31:0] r_rtol;
    logic [31:0] r_atol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp16 <= 1'b0;
            r_rtol <= '0;
            r_atol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ELEMENT_FORMAT: r_fp16 <= i_cfg_data[0];
                CFG_RELATIVE_TOL:   r_rtol <= i_cfg_data;
                CFG_ABSOLUTE_TOL:   r_atol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item front_item;
    t_item head_item;

    ftac_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value_a      (i_value_a),
        .i_value_b      (i_value_b),
        .i_last_element (i_last_element),
        .i_fp16         (r_fp16),
        .i_queue_full   (full),
        .o_push         (push),
        .o_item         (front_item)
    );

    ftac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    ftac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .i_rtol      (r_rtol),
        .i_atol      (r_atol),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_all_close (o_all_close)
    );

endmodule

`default_nettype wire

>>> rtl/ftac_front.sv
// Front end: input handshake, fp16 widening and classification of each pair.
// Depends on ftac_pkg; feeds ftac_queue.
`default_nettype none

module ftac_front (
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [31:0]   i_value_a,
    input  wire logic [31:0]   i_value_b,
    input  wire logic          i_last_element,
    input  wire logic          i_fp16,
    input  wire logic          i_queue_full,
    output logic               o_push,
    output ftac_pkg::t_item    o_item
);
    import ftac_pkg::*;

    function automatic logic [3:0] lzc10(input logic [9:0] v);
        logic [3:0] n;
        logic       found;
        n = 4'd10;
        found = 1'b0;
        for (int i = 9; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 4'(9 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Exact fp16 to fp32 widening, subnormals normalized.
    function automatic logic [31:0] widen(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] fr;
        logic [3:0] lz;
        logic [9:0] frn;
        s  = h[15];
        ex = h[14:10];
        fr = h[9:0];
        lz = lzc10(fr);
        frn = 10'({1'b0, fr} << (lz + 4'd1));
        if (ex == 5'd0) begin
            if (fr == 10'd0) begin
                return {s, 31'd0};
            end
            return {s, 8'd112 - {4'd0, lz}, frn, 13'd0};
        end
        if (ex == 5'h1F) begin
            return {s, 8'hFF, fr, 13'd0};
        end
        return {s, {3'd0, ex} + 8'd112, fr, 13'd0};
    endfunction

    logic [31:0] a;
    logic [31:0] b;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic        a_ge;

    always_comb begin
        a = i_fp16 ? widen(i_value_a[15:0]) : i_value_a;
        b = i_fp16 ? widen(i_value_b[15:0]) : i_value_b;
        nan_a = a[30:0] > F32_INF_MAG;
        nan_b = b[30:0] > F32_INF_MAG;
        inf_a = a[30:0] == F32_INF_MAG;
        inf_b = b[30:0] == F32_INF_MAG;
        a_ge  = a[30:0] >= b[30:0];

        o_item.mag_x   = a_ge ? a[30:0] : b[30:0];
        o_item.mag_y   = a_ge ? b[30:0] : a[30:0];
        o_item.eff_sub = a[31] == b[31];
        o_item.diff_nan = nan_a | nan_b | (inf_a & inf_b & (a[31] == b[31]));
        o_item.diff_inf = (inf_a | inf_b) & !o_item.diff_nan;
        // max ignores a NaN when the other side is a number
        if (nan_a) begin
            o_item.m_mag = b[30:0];
        end else if (nan_b) begin
            o_item.m_mag = a[30:0];
        end else begin
            o_item.m_mag = o_item.mag_x;
        end
        o_item.last = i_last_element;
    end

    assign o_stall = i_queue_full;
    assign o_push  = i_valid & !i_queue_full;

endmodule

`default_nettype wire

>>> rtl/ftac_queue.sv
// Short FIFO of classified pairs between the front and the back.
// Depends on ftac_pkg.
`default_nettype none

module ftac_queue #(
    parameter int DEPTH = ftac_pkg::FTAC_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ftac_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output ftac_pkg::t_item      o_item
);
    import ftac_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ftac_back.sv
// Back end: fp32 subtract and multiply with round-to-nearest-even, tolerance
// compares, sticky mismatch flag and verdict output register. Uses ftac_pkg.
`default_nettype none

module ftac_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  wire ftac_pkg::t_item i_item,
    output logic                 o_pop,
    input  wire logic [31:0]     i_rtol,
    input  wire logic [31:0]     i_atol,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_all_close
);
    import ftac_pkg::*;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd48;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 6'(47 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Round to nearest even; e is at least 1, mant[23] is the hidden bit.
    function automatic logic [30:0] round_pack(input logic signed [11:0] e,
                                               input logic [23:0] mant,
                                               input logic g,
                                               input logic s);
        logic               up;
        logic [24:0]        mr;
        logic signed [11:0] ef;
        up = g & (s | mant[0]);
        mr = {1'b0, mant} + 25'(up);
        if (mr[24]) begin
            ef = e + 12'sd1;
        end else if (mr[23]) begin
            ef = e;
        end else begin
            ef = '0;
        end
        if (ef >= 12'sd255) begin
            return F32_INF_MAG;
        end
        return {ef[7:0], mr[22:0]};
    endfunction

    function automatic logic f32_gt(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] kx;
        logic [31:0] ky;
        kx = x[31] ? ~x : {1'b1, x[30:0]};
        ky = y[31] ? ~y : {1'b1, y[30:0]};
        if (x[30:0] > F32_INF_MAG || y[30:0] > F32_INF_MAG) begin
            return 1'b0;
        end
        if (x[30:0] == 31'd0 && y[30:0] == 31'd0) begin
            return 1'b0;
        end
        return kx > ky;
    endfunction

    t_state             r_state;
    t_state             n_state;
    t_item              r_item;
    logic [27:0]        r_sum;
    logic [7:0]         r_sum_e;
    logic [47:0]        r_prod;
    logic [8:0]         r_prod_e;
    logic               r_lim_nan;
    logic               r_lim_inf;
    logic [26:0]        r_dm;
    logic signed [11:0] r_de;
    logic [47:0]        r_pn;
    logic signed [11:0] r_pe;
    logic [30:0]        r_diff;
    logic [31:0]        r_lim;
    logic               r_mismatch;
    logic               r_all_close;

    // align and add, multiply
    logic [7:0]  xe;
    logic [7:0]  ye;
    logic [23:0] mx;
    logic [23:0] my;
    logic [7:0]  d;
    logic [4:0]  dc;
    logic [53:0] bfull;
    logic [26:0] bal;
    logic [27:0] ax;
    logic [27:0] n_sum;
    logic [7:0]  re;
    logic [7:0]  me;
    logic [23:0] rm;
    logic [23:0] mm;
    logic [47:0] n_prod;
    logic [8:0]  n_prod_e;
    logic        n_lim_nan;
    logic        n_lim_inf;
    logic        rnan;
    logic        rinf;
    logic        rzero;
    logic        mnan;
    logic        minf;
    logic        mzero;

    always_comb begin
        xe = (r_item.mag_x[30:23] == 8'd0) ? 8'd1 : r_item.mag_x[30:23];
        ye = (r_item.mag_y[30:23] == 8'd0) ? 8'd1 : r_item.mag_y[30:23];
        mx = {r_item.mag_x[30:23] != 8'd0, r_item.mag_x[22:0]};
        my = {r_item.mag_y[30:23] != 8'd0, r_item.mag_y[22:0]};
        d  = xe - ye;
        dc = (d > 8'd27) ? 5'd27 : d[4:0];
        bfull = {my, 30'd0} >> dc;
        bal = {bfull[53:28], bfull[27] | (|bfull[26:0])};
        ax = {1'b0, mx, 3'd0};
        n_sum = r_item.eff_sub ? ax - {1'b0, bal} : ax + {1'b0, bal};

        re = (i_rtol[30:23] == 8'd0) ? 8'd1 : i_rtol[30:23];
        me = (r_item.m_mag[30:23] == 8'd0) ? 8'd1 : r_item.m_mag[30:23];
        rm = {i_rtol[30:23] != 8'd0, i_rtol[22:0]};
        mm = {r_item.m_mag[30:23] != 8'd0, r_item.m_mag[22:0]};
        n_prod   = 48'(rm) * 48'(mm);
        n_prod_e = {1'b0, re} + {1'b0, me};

        rnan  = i_rtol[30:0] > F32_INF_MAG;
        rinf  = i_rtol[30:0] == F32_INF_MAG;
        rzero = i_rtol[30:0] == 31'd0;
        mnan  = r_item.m_mag > F32_INF_MAG;
        minf  = r_item.m_mag == F32_INF_MAG;
        mzero = r_item.m_mag == 31'd0;
        n_lim_nan = rnan | mnan | (rinf & mzero) | (minf & rzero);
        n_lim_inf = (rinf | minf) & !n_lim_nan;
    end

    // normalize
    logic [4:0]         lz27;
    logic [7:0]         sh;
    logic [7:0]         sh_max;
    logic [26:0]        n_dm;
    logic signed [11:0] n_de;
    logic [5:0]         lz48;
    logic [47:0]        n_pn;
    logic signed [11:0] n_pe;

    always_comb begin
        lz27   = lzc27(r_sum[26:0]);
        sh_max = r_sum_e - 8'd1;
        sh     = ({3'd0, lz27} > sh_max) ? sh_max : {3'd0, lz27};
        if (r_sum[27]) begin
            n_dm = {r_sum[27:2], r_sum[1] | r_sum[0]};
            n_de = $signed({4'd0, r_sum_e}) + 12'sd1;
        end else begin
            n_dm = r_sum[26:0] << sh;
            n_de = $signed({4'd0, r_sum_e}) - $signed({4'd0, sh});
        end
        lz48 = lzc48(r_prod);
        n_pn = r_prod << lz48;
        n_pe = $signed({3'd0, r_prod_e}) - 12'sd126 - $signed({6'd0, lz48});
    end

    // round
    logic signed [11:0] rs;
    logic [5:0]         rsc;
    logic signed [11:0] pe_eff;
    logic [95:0]        pw;
    logic [30:0]        diff_r;
    logic [30:0]        lim_r;
    logic [30:0]        n_diff;
    logic [31:0]        n_lim;

    always_comb begin
        rs = 12'sd1 - r_pe;
        if (r_pe < 12'sd1) begin
            rsc    = (rs > 12'sd49) ? 6'd49 : rs[5:0];
            pe_eff = 12'sd1;
        end else begin
            rsc    = 6'd0;
            pe_eff = r_pe;
        end
        pw = {r_pn, 48'd0} >> rsc;
        diff_r = round_pack(r_de, r_dm[26:3], r_dm[2], r_dm[1] | r_dm[0]);
        lim_r  = round_pack(pe_eff, pw[95:72], pw[71], |pw[70:0]);
        if (r_item.diff_nan) begin
            n_diff = F32_NAN_MAG;
        end else if (r_item.diff_inf) begin
            n_diff = F32_INF_MAG;
        end else begin
            n_diff = diff_r;
        end
        if (r_lim_nan) begin
            n_lim = {i_rtol[31], F32_NAN_MAG};
        end else if (r_lim_inf) begin
            n_lim = {i_rtol[31], F32_INF_MAG};
        end else begin
            n_lim = {i_rtol[31], lim_r};
        end
    end

    logic fail;
    assign fail = f32_gt({1'b0, r_diff}, i_atol) & f32_gt({1'b0, r_diff}, r_lim);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_ALIGN;
            ST_ALIGN: n_state = ST_NORM;
            ST_NORM:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_CHECK;
            ST_CHECK: n_state = r_item.last ? ST_OUT : ST_IDLE;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == ST_IDLE) && !i_empty;
        o_valid = r_state == ST_OUT;
    end

    assign o_all_close = r_all_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mismatch <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CHECK) begin
                // clear the sticky flag with each verdict
                r_mismatch <= r_item.last ? 1'b0 : (r_mismatch | fail);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == ST_ALIGN) begin
            r_sum     <= n_sum;
            r_sum_e   <= xe;
            r_prod    <= n_prod;
            r_prod_e  <= n_prod_e;
            r_lim_nan <= n_lim_nan;
            r_lim_inf <= n_lim_inf;
        end
        if (r_state == ST_NORM) begin
            r_dm <= n_dm;
            r_de <= n_de;
            r_pn <= n_pn;
            r_pe <= n_pe;
        end
        if (r_state == ST_ROUND) begin
            r_diff <= n_diff;
            r_lim  <= n_lim;
        end
        if (r_state == ST_CHECK) begin
            r_all_close <= !(r_mismatch | fail);
        end
    end

endmodule

`default_nettype wire

>>> rtl/ftac_checker.sv
// Port-level checks for float_tensor_allclose_checker, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module ftac_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic o_all_close
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_all_close))
        else $error("verdict changed while stalled");

    // one transfer per verdict, never two in a row
    a_single_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("verdict repeated");

    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("verdict shown right after reset");

    a_reset_queue: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind float_tensor_allclose_checker ftac_checker u_ftac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_all_close (o_all_close)
);

`default_nettype wire

>>> tb/sv/allclose_checker.sv
// Watches both channels and the register port of the all-close checker.
// Predicts every verdict in fp32 terms and compares; depends on ftac_pkg.
`timescale 1ns / 1ps

module allclose_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic                             i_in_stall,
    input  wire logic [31:0]                      i_value_a,
    input  wire logic [31:0]                      i_value_b,
    input  wire logic                             i_last_element,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic                             i_all_close,
    input  wire logic                             i_cfg_we,
    input  wire logic [ftac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ftac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                    o_errors,
    output int                                    o_pending
);
    import ftac_pkg::*;

    localparam logic [31:0] QNAN = 32'h7FC00000;
    localparam logic [31:0] INF  = 32'h7F800000;

    logic        half_mode;
    logic [31:0] rtol_bits;
    logic [31:0] atol_bits;
    logic        mismatch_flag;
    logic        verdicts[$];

    function automatic logic is_nan(logic [31:0] f);
        return f[30:0] > INF[30:0];
    endfunction

    function automatic logic is_inf(logic [31:0] f);
        return f[30:0] == INF[30:0];
    endfunction

    function automatic logic [31:0] widen_half(logic [15:0] h);
        logic [31:0] frac;
        int          shift;
        frac  = {9'd0, h[9:0], 13'd0};
        shift = 0;
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, frac[22:0]};
        if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10] + 112), frac[22:0]};
        if (frac == 0) return {h[15], 31'd0};
        while (!frac[23]) begin
            frac  = frac << 1;
            shift = shift + 1;
        end
        return {h[15], 8'(113 - shift), frac[22:0]};
    endfunction

    function automatic real pow2(int k);
        return $bitstoreal({1'b0, 11'(1023 + k), 52'd0});
    endfunction

    // finite operands only
    function automatic real to_real(logic [31:0] f);
        real r;
        if (f[30:23] == 8'd0)
            r = real'(f[22:0]) * pow2(-149);
        else
            r = real'({1'b1, f[22:0]}) * pow2(int'(f[30:23]) - 150);
        return f[31] ? -r : r;
    endfunction

    // round a non-negative finite real to fp32, nearest even
    function automatic logic [31:0] round_mag(real r);
        logic [63:0] d;
        logic [63:0] m53;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e32;
        int          shift;
        if (r == 0.0) return 32'd0;
        d     = $realtobits(r);
        e32   = int'(d[62:52]) - 1023 + 127;
        m53   = {11'd0, 1'b1, d[51:0]};
        shift = (e32 >= 1) ? 29 : 30 - e32;
        if (shift > 60) return 32'd0;
        kept = m53 >> shift;
        rem  = m53 & ((64'd1 << shift) - 1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        if (e32 < 1) return kept[31:0];
        if (kept[24]) begin
            kept = kept >> 1;
            e32  = e32 + 1;
        end
        if (e32 >= 255) return INF;
        return {1'b0, 8'(e32), kept[22:0]};
    endfunction

    function automatic longint order_key(logic [31:0] f);
        return f[31] ? -longint'(f[30:0]) : longint'(f[30:0]);
    endfunction

    function automatic logic greater(logic [31:0] x, logic [31:0] y);
        if (is_nan(x) || is_nan(y)) return 1'b0;
        return order_key(x) > order_key(y);
    endfunction

    function automatic logic pair_fails(logic [31:0] raw_a, logic [31:0] raw_b);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] diff;
        logic [31:0] mag;
        logic [31:0] lim;
        logic [31:0] prod;
        a = half_mode ? widen_half(raw_a[15:0]) : raw_a;
        b = half_mode ? widen_half(raw_b[15:0]) : raw_b;
        if (is_nan(a) || is_nan(b))
            diff = QNAN;
        else if (is_inf(a) && is_inf(b))
            diff = (a[31] == b[31]) ? QNAN : INF;
        else if (is_inf(a) || is_inf(b))
            diff = INF;
        else
            diff = round_mag((to_real(a) - to_real(b) < 0.0) ?
                             to_real(b) - to_real(a) : to_real(a) - to_real(b));
        // largest magnitude, a NaN loses against a number
        if (is_nan({1'b0, a[30:0]}))
            mag = {1'b0, b[30:0]};
        else if (is_nan({1'b0, b[30:0]}))
            mag = {1'b0, a[30:0]};
        else
            mag = (a[30:0] > b[30:0]) ? {1'b0, a[30:0]} : {1'b0, b[30:0]};
        if (is_nan(rtol_bits) || is_nan(mag))
            lim = QNAN;
        else if (is_inf(rtol_bits) || is_inf(mag))
            lim = (rtol_bits[30:0] == 0 || mag[30:0] == 0) ? QNAN : {rtol_bits[31], INF[30:0]};
        else begin
            prod = round_mag(to_real({1'b0, rtol_bits[30:0]}) * to_real(mag));
            lim  = {rtol_bits[31], prod[30:0]};
        end
        return greater(diff, atol_bits) && greater(diff, lim);
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            half_mode     = 1'b0;
            rtol_bits     = 32'd0;
            atol_bits     = 32'd0;
            mismatch_flag = 1'b0;
            verdicts.delete();
            o_errors     <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ELEMENT_FORMAT: half_mode = i_cfg_data[0];
                    CFG_RELATIVE_TOL:   rtol_bits = i_cfg_data;
                    CFG_ABSOLUTE_TOL:   atol_bits = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdicts.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected verdict %0b at %0t", i_all_close, $realtime);
                    o_errors <= o_errors + 1;
                end else begin
                    want = verdicts.pop_front();
                    if (want !== i_all_close) begin
                        if (o_errors < 10)
                            $display("all_close mismatch: expected %0b got %0b at %0t",
                                     want, i_all_close, $realtime);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                if (pair_fails(i_value_a, i_value_b)) mismatch_flag = 1'b1;
                if (i_last_element) begin
                    verdicts.push_back(!mismatch_flag);
                    mismatch_flag = 1'b0;
                end
            end
            o_pending <= verdicts.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the all-close checker testbench: clock, reset, stimulus and verdict.
// Depends on ftac_pkg, float_tensor_allclose_checker and allclose_checker.
`timescale 1ns / 1ps

module testbench;
    import ftac_pkg::*;

    localparam logic FMT_FP32 = 1'b0;
    localparam logic FMT_FP16 = 1'b1;
    localparam int   ITEMS_PER_PHASE = 235;
    localparam int   NUM_PHASES = 8;
    localparam int   CYCLE_LIMIT = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [31:0]           i_value_a = 32'd0;
    logic [31:0]           i_value_b = 32'd0;
    logic                  i_last_element = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_all_close;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ELEMENT_FORMAT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int                    errors;
    int                    pending;
    logic                  hold_req = 1'b0;
    logic                  sender_quiet = 1'b0;
    logic                  cur_fmt = FMT_FP32;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    float_tensor_allclose_checker DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_value_a, .i_value_b, .i_last_element,
        .o_valid, .i_stall, .o_all_close, .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    allclose_checker scoreboard (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_value_a, .i_value_b,
        .i_last_element, .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_all_close(o_all_close), .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send(logic [31:0] a, logic [31:0] b, logic last);
        int n;
        n = sender_quiet ? 0 : gap_len();
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_value_a      <= a;
        i_value_b      <= b;
        i_last_element <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    // wait out every verdict plus the pairs still in flight behind it
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_settings(logic fmt, logic [31:0] rtol, logic [31:0] atol);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ELEMENT_FORMAT;
        i_cfg_data  <= {31'($urandom), fmt};
        @(posedge i_clk);
        i_cfg_index <= CFG_RELATIVE_TOL;
        i_cfg_data  <= rtol;
        @(posedge i_clk);
        i_cfg_index <= CFG_ABSOLUTE_TOL;
        i_cfg_data  <= atol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_fmt      = fmt;
    endtask

    function automatic logic [31:0] special_value();
        logic [31:0] pick[10];
        pick = '{32'h0, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
                 32'h7F7FFFFF, 32'h00000001, 32'h3F800000, 32'h7C00, 32'h03FF};
        return pick[$urandom_range(0, 9)];
    endfunction

    function automatic logic [31:0] near_value(logic [31:0] a);
        case ($urandom_range(0, 6))
            0, 1: return a;
            2:    return a + $urandom_range(0, 15);
            3:    return a ^ (32'd1 << $urandom_range(0, cur_fmt ? 9 : 22));
            4:    return a ^ (cur_fmt ? 32'h8000 : 32'h80000000);
            5:    return special_value();
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_pair(logic last);
        logic [31:0] a;
        logic [31:0] b;
        if ($urandom_range(0, 3) == 0)
            a = $urandom;
        else if (cur_fmt == FMT_FP16)
            a = {16'($urandom), 1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
        else
            a = {1'($urandom), 8'($urandom_range(90, 160)), 23'($urandom)};
        b = near_value(a);
        if (cur_fmt == FMT_FP16) b[31:16] = 16'($urandom);
        if ($urandom_range(0, 1)) send(a, b, last);
        else send(b, a, last);
    endtask

    initial begin
        logic [31:0] rtols[NUM_PHASES];
        logic [31:0] atols[NUM_PHASES];
        int          sent;
        int          len;
        rtols = '{32'h3727C5AC, 32'h3A83126F, 32'h00000000, 32'h7F800000,
                  32'h7FC00000, 32'hBF800000, 32'h7F7FFFFF, 32'h3C23D70A};
        atols = '{32'h322BCC77, 32'h3A83126F, 32'hFFFFFFFF, 32'h00000000,
                  32'h00000001, 32'h7FC00000, 32'h7F800000, 32'hB8D1B717};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset tolerances: any difference between finite operands fails, NaN and inf pass
        send(32'h00000000, 32'h80000000, 1'b1);
        send(32'h3F800000, 32'h3F800000, 1'b0);
        send(32'h3F800000, 32'h3F800001, 1'b1);
        send(32'h7F800000, 32'h7F800000, 1'b1);
        send(32'h7F800000, 32'hFF800000, 1'b1);
        send(32'h7FC00000, 32'h3F800000, 1'b0);
        send(32'hFFFFFFFF, 32'h00000000, 1'b1);
        send(32'h7F7FFFFF, 32'hFF7FFFFF, 1'b1);
        send(32'h00000001, 32'h00000000, 1'b1);
        drain();
        write_settings(FMT_FP32, 32'h3F800000, 32'h00000000);
        send(32'h7F7FFFFF, 32'h00000000, 1'b1);
        send(32'h00000001, 32'h80000001, 1'b1);
        drain();
        write_settings(FMT_FP16, 32'h00000000, 32'h00000000);
        send(32'hFFFF3C00, 32'h00003C00, 1'b1);
        send(32'h00000001, 32'h00000000, 1'b1);
        send(32'h000003FF, 32'h000003FF, 1'b0);
        send(32'h00007C00, 32'h00007C00, 1'b1);
        send(32'h00007C00, 32'h0000FC00, 1'b1);
        send(32'h00007E00, 32'h00000000, 1'b1);
        send(32'h00007BFF, 32'h0000FBFF, 1'b1);
        send(32'hA5A58001, 32'h5A5A0000, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_settings(p[0] ? FMT_FP16 : FMT_FP32, rtols[p], atols[p]);
            sender_quiet = (p % 3 == 2);
            if (p == 1) begin
                sender_quiet = 1'b1;
                hold_req     = 1'b1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_random_pair(k == len - 1);
                    sent++;
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random holds, one long hold-off when asked
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else begin
                n = gap_len();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
